// File: sv/ts_pid_rate_and_cc_monitor_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PID rate and continuity counter monitor
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TS_PID_RATE_AND_CC_MONITOR_TOP_DEFINES_SVH
`define TS_PID_RATE_AND_CC_MONITOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPCM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tpcm_pkg.sv
// ----------------------------------------------------------------------------
// PID rate and continuity counter monitor package
// Table geometry, register map, entry layout and controller states.
// ----------------------------------------------------------------------------
package tpcm_pkg;

   localparam int PID_ENTRIES = 8192;
   localparam int PID_W       = $clog2(PID_ENTRIES);
   localparam int ADDR_W      = 3;

   localparam logic [4:0]  CC_INVALID        = 5'h10;
   localparam logic [15:0] RATE_WINDOW_RESET = 16'd100;
   localparam logic [19:0] STALE_LIMIT_RESET = 20'd500;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_SWEEP  = 1'b1;

   localparam logic REG_RATE_WINDOW = 1'b0;
   localparam logic REG_STALE_LIMIT = 1'b1;

   typedef struct packed {
      logic        seen;
      logic [4:0]  prev_cc;
      logic [7:0]  err_cnt;
      logic [31:0] win_cnt;
      logic [31:0] win_start;
      logic [31:0] total;
      logic [31:0] latched;
      logic [31:0] lowest;
      logic [31:0] highest;
   } entry_type;

   localparam entry_type ENTRY_CLEAR = '{
      seen:      1'b0,
      prev_cc:   CC_INVALID,
      err_cnt:   8'd0,
      win_cnt:   32'd0,
      win_start: 32'd0,
      total:     32'd0,
      latched:   32'd0,
      lowest:    32'd0,
      highest:   32'd0
   };

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_EVAL  = 6'b000100,
      S_WRITE = 6'b001000,
      S_SWEEP = 6'b010000,
      S_DRAIN = 6'b100000
   } state_type;

endpackage

// File: sv/ts_pid_rate_and_cc_monitor_top.sv
// ----------------------------------------------------------------------------
// PID rate and continuity counter monitor
// Per-PID statistics table held in one synchronous memory, updated by
// read-modify-write for each packet header and swept for stale entries.
// ----------------------------------------------------------------------------
// A packet request passes through memory read, evaluation and write-back, and no
// new request is accepted before write-back; its response is registered at write-back,
// which waits while a pending response is stalled. A sweep request walks the whole
// table, one entry per cycle through the single memory read port, and responds once
// the sweep pipeline has drained. After reset a clearing pass writes every entry,
// during which requests are stalled; register writes are taken.
`include "ts_pid_rate_and_cc_monitor_top_defines.svh"

module ts_pid_rate_and_cc_monitor_top
   import tpcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [12:0]       req_pid,
   input  logic [3:0]        req_cont_count,
   input  logic [31:0]       req_now,
   input  logic              req_last_of_burst,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_cc_mismatch,
   output logic [31:0]       rsp_pid_rate,
   output logic [31:0]       rsp_pid_min_rate,
   output logic [31:0]       rsp_pid_max_rate,
   output logic [31:0]       rsp_pid_total,
   output logic [7:0]        rsp_pid_cc_errors,
   output logic              rsp_burst_end,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   state_type        state_ff, state_in;
   logic [PID_W-1:0] cnt_ff, cnt_in;
   logic             cnt_last;

   logic [15:0]      rate_window_ff;
   logic [19:0]      stale_limit_ff;
   logic             cfg_wr;

   logic [12:0]      pid_ff;
   logic [3:0]       cc_ff;
   logic [31:0]      now_ff;
   logic             lob_ff;
   logic             req_acc;
   logic             pid_in_range;

   entry_type        mem [PID_ENTRIES];
   logic             rd_en;
   logic [PID_W-1:0] rd_addr;
   entry_type        rdata_ff;
   logic             wr_en;
   logic [PID_W-1:0] wr_addr;
   entry_type        wr_data;

   entry_type        ent_ff;
   logic [31:0]      wc_inc_ff;
   logic [31:0]      tot_inc_ff;
   logic [31:0]      win_end_ff;
   logic             mismatch_ff;
   logic [7:0]       err_new_ff;
   logic             eval_mismatch;
   logic [31:0]      win_diff;
   logic             elapsed;
   entry_type        upd;

   logic             s1_vld_ff;
   logic [PID_W-1:0] s1_addr_ff;
   logic             s2_vld_ff;
   logic [PID_W-1:0] s2_addr_ff;
   logic [31:0]      s2_sum_ff;
   logic [31:0]      stale_diff;
   logic             stale;

   logic             out_free;
   logic             out_load;
   logic             out_mismatch;
   logic [31:0]      out_rate;
   logic [31:0]      out_min;
   logic [31:0]      out_max;
   logic [31:0]      out_total;
   logic [7:0]       out_err;
   logic             out_burst;
   logic             rsp_valid_ff;

   // Configuration port.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_window_ff <= RATE_WINDOW_RESET;
         stale_limit_ff <= STALE_LIMIT_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            REG_RATE_WINDOW: rate_window_ff <= pwdata[15:0];
            REG_STALE_LIMIT: stale_limit_ff <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RATE_WINDOW: prdata = {16'd0, rate_window_ff};
         REG_STALE_LIMIT: prdata = {12'd0, stale_limit_ff};
         default:         prdata = '0;
      endcase
   end

   // Request capture.
   assign req_stall    = (state_ff != S_IDLE);
   assign req_acc      = req_valid && !req_stall;
   assign pid_in_range = ({19'd0, pid_ff} < 32'(PID_ENTRIES));
   assign cnt_last     = (cnt_ff == PID_W'(PID_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pid_ff <= req_pid;
         cc_ff  <= req_cont_count;
         now_ff <= req_now;
         lob_ff <= req_last_of_burst;
      end
   end

   // Statistics memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Evaluation stage of a packet update.
   assign eval_mismatch = (rdata_ff.prev_cc != CC_INVALID) &&
                          ((rdata_ff.prev_cc[3:0] + 4'd1) != cc_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         ent_ff      <= rdata_ff;
         wc_inc_ff   <= rdata_ff.win_cnt + 32'd1;
         tot_inc_ff  <= rdata_ff.total + 32'd1;
         win_end_ff  <= rdata_ff.win_start + {16'd0, rate_window_ff};
         mismatch_ff <= eval_mismatch;
         err_new_ff  <= eval_mismatch ? rdata_ff.err_cnt + 8'd1 : rdata_ff.err_cnt;
      end
   end

   // Write-back value of a packet update.
   assign win_diff = win_end_ff - now_ff;
   assign elapsed  = !ent_ff.seen || win_diff[31];

   always_comb begin
      upd         = ent_ff;
      upd.win_cnt = wc_inc_ff;
      upd.total   = tot_inc_ff;
      upd.prev_cc = {1'b0, cc_ff};
      upd.err_cnt = err_new_ff;
      if (elapsed) begin
         upd.seen      = 1'b1;
         upd.win_start = now_ff;
         upd.latched   = wc_inc_ff;
         upd.win_cnt   = 32'd0;
         if ((wc_inc_ff > ent_ff.highest) || (ent_ff.highest == 32'd0)) begin
            upd.highest = wc_inc_ff;
         end
         if ((wc_inc_ff < ent_ff.lowest) || (ent_ff.lowest == 32'd0)) begin
            upd.lowest = wc_inc_ff;
         end
      end
   end

   // Sweep pipeline: read, add the stale limit, compare and clear.
   assign stale_diff = s2_sum_ff - now_ff;
   assign stale      = stale_diff[31];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == S_SWEEP);
         s2_vld_ff <= s1_vld_ff;
      end
      s1_addr_ff <= cnt_ff;
      s2_addr_ff <= s1_addr_ff;
      s2_sum_ff  <= rdata_ff.win_start + {12'd0, stale_limit_ff};
   end

   // Controller.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_en        = 1'b0;
      rd_addr      = req_pid[PID_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = ENTRY_CLEAR;
      out_load     = 1'b0;
      out_mismatch = 1'b0;
      out_rate     = 32'd0;
      out_min      = 32'd0;
      out_max      = 32'd0;
      out_total    = 32'd0;
      out_err      = 8'd0;
      out_burst    = 1'b0;
      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + PID_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_SWEEP) begin
                  cnt_in   = '0;
                  state_in = S_SWEEP;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_burst = lob_ff;
               if (pid_in_range) begin
                  wr_en        = 1'b1;
                  wr_addr      = pid_ff[PID_W-1:0];
                  wr_data      = upd;
                  out_mismatch = mismatch_ff;
                  out_rate     = upd.latched;
                  out_min      = upd.lowest;
                  out_max      = upd.highest;
                  out_total    = upd.total;
                  out_err      = upd.err_cnt;
               end
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            rd_en   = 1'b1;
            rd_addr = cnt_ff;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + PID_W'(1);
            end
         end
         S_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && out_free) begin
               out_load  = 1'b1;
               out_burst = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (s2_vld_ff && stale) begin
         wr_en   = 1'b1;
         wr_addr = s2_addr_ff;
         wr_data = ENTRY_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_cc_mismatch   <= out_mismatch;
         rsp_pid_rate      <= out_rate;
         rsp_pid_min_rate  <= out_min;
         rsp_pid_max_rate  <= out_max;
         rsp_pid_total     <= out_total;
         rsp_pid_cc_errors <= out_err;
         rsp_burst_end     <= out_burst;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TPCM_ASSERT_NEXT(a_packet_to_eval, req_acc && (req_op == OP_PACKET),
                     state_ff == S_EVAL, "packet request did not move to evaluation")
   `TPCM_ASSERT_SAME(a_sweep_pipe_state, s2_vld_ff,
                     (state_ff == S_SWEEP) || (state_ff == S_DRAIN),
                     "sweep pipeline active outside a sweep")
   `TPCM_ASSERT_SAME(a_write_in_range, wr_en && (state_ff == S_WRITE), pid_in_range,
                     "table written for a PID beyond the table")
   `TPCM_ASSERT_SAME(a_no_overwrite, out_load, !(rsp_valid_ff && rsp_stall),
                     "pending response overwritten")

endmodule
